FILE: src/vector_gcd_normalizer_top_defines.svh
// Assertion macros used by the vector GCD normalizer back end.
`ifndef VECTOR_GCD_NORMALIZER_TOP_DEFINES_SVH
`define VECTOR_GCD_NORMALIZER_TOP_DEFINES_SVH

// Combinational implication checked at every rising edge outside reset.
`define VGN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define VGN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/vgn_pkg.sv
// Types and constants of the vector GCD normalizer.
package vgn_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  typedef struct packed {
    logic kind;
    logic first;
    logic close;
  } vgn_ctrl_t;

  typedef enum logic [2:0] {
    B_LOAD,
    B_GCD_NEXT,
    B_GCD_EUC,
    B_GCD_WAIT,
    B_EMIT_SEL,
    B_EMIT_WAIT,
    B_EMIT_OUT
  } vgn_state_e;

endpackage

FILE: src/vgn_front.sv
// Front end: accepts coefficients, marks vector boundaries and queues them.
module vgn_front import vgn_pkg::*; #(
  parameter int unsigned MAX_COLS   = 16,
  parameter int unsigned COEF_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic                  last_i,
  input  logic [COEF_WIDTH-1:0] coef_i,
  output logic                  q_valid_o,
  input  logic                  q_pop_i,
  output vgn_ctrl_t             q_ctrl_o,
  output logic [COEF_WIDTH-1:0] q_coef_o
);

  localparam int unsigned CW = $clog2(MAX_COLS + 1);

  logic [CW-1:0]          cnt_q, cnt_d;
  vgn_ctrl_t              ctrl_mem_q [QueueDepth];
  logic [COEF_WIDTH-1:0]  coef_mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QueuePtrW:0]     fill_q, fill_d;
  logic                   push, pop;
  vgn_ctrl_t              ctrl_in;

  assign in_ready_o = (fill_q != (QueuePtrW + 1)'(QueueDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (fill_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_ctrl_o   = ctrl_mem_q[rd_q];
  assign q_coef_o   = coef_mem_q[rd_q];

  // A vector closes on last or when it reaches the maximum length.
  always_comb begin
    ctrl_in.kind  = kind_i;
    ctrl_in.first = (cnt_q == '0);
    ctrl_in.close = last_i || (cnt_q == CW'(MAX_COLS - 1));
    cnt_d  = cnt_q;
    if (push) begin
      cnt_d = ctrl_in.close ? '0 : cnt_q + 1'b1;
    end
    wr_d   = push ? wr_q + 1'b1 : wr_q;
    rd_d   = pop ? rd_q + 1'b1 : rd_q;
    fill_d = fill_q + (QueuePtrW + 1)'(push) - (QueuePtrW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctrl_mem_q[wr_q] <= ctrl_in;
      coef_mem_q[wr_q] <= coef_i;
    end
  end

endmodule

FILE: src/vgn_div.sv
// Restoring divider that produces one quotient bit per cycle.
module vgn_div #(
  parameter int unsigned COEF_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COEF_WIDTH-1:0] dividend_i,
  input  logic [COEF_WIDTH-1:0] divisor_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [COEF_WIDTH-1:0] quotient_o,
  output logic [COEF_WIDTH-1:0] remainder_o
);

  localparam int unsigned NW = $clog2(COEF_WIDTH + 1);

  logic [NW-1:0]         cnt_q, cnt_d;
  logic                  busy_q, busy_d, done_q, done_d;
  logic [COEF_WIDTH-1:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [COEF_WIDTH:0]   trial;

  assign trial       = {rem_q, quo_q[COEF_WIDTH-1]};
  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = NW'(COEF_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = COEF_WIDTH'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[COEF_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = trial[COEF_WIDTH-1:0];
        quo_d = {quo_q[COEF_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == NW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

endmodule

FILE: src/vgn_back.sv
// Back end: stores a vector, finds the GCD of counted magnitudes, emits it divided.
module vgn_back import vgn_pkg::*; #(
  parameter int unsigned MAX_COLS   = 16,
  parameter int unsigned COEF_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_pop_o,
  input  vgn_ctrl_t             q_ctrl_i,
  input  logic [COEF_WIDTH-1:0] q_coef_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COEF_WIDTH-1:0] out_coef_o,
  output logic                  out_changed_o,
  output logic [COEF_WIDTH-1:0] out_divisor_o,
  output logic                  out_last_o
);
  `include "vector_gcd_normalizer_top_defines.svh"

  localparam int unsigned CW = $clog2(MAX_COLS + 1);
  localparam int unsigned IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  vgn_state_e            state_q, state_d;
  logic [COEF_WIDTH-1:0] store_q [MAX_COLS];
  logic [CW-1:0]         n_q, n_d, idx_q, idx_d;
  logic                  mode_q, mode_d;
  logic [COEF_WIDTH-1:0] g_q, g_d, a_q, a_d, b_q, b_d, res_q, res_d;
  logic                  neg_q, neg_d;
  logic                  ov_q, ov_d, ochg_q, ochg_d, olast_q, olast_d;
  logic [COEF_WIDTH-1:0] ores_q, ores_d, odiv_q, odiv_d;
  logic [COEF_WIDTH-1:0] cur, cur_mag;
  logic                  divide, counted, wr_en, out_free;
  logic [IW-1:0]         wr_idx;
  logic                  div_start, div_busy, div_done;
  logic [COEF_WIDTH-1:0] div_a, div_b, div_quo, div_rem;

  assign cur      = store_q[idx_q[IW-1:0]];
  assign cur_mag  = cur[COEF_WIDTH-1] ? (~cur + 1'b1) : cur;
  assign divide   = (g_q > COEF_WIDTH'(1));
  assign counted  = mode_q || (idx_q != '0);
  assign out_free = !ov_q || out_ready_i;
  assign wr_idx   = q_ctrl_i.first ? '0 : n_q[IW-1:0];

  vgn_div #(.COEF_WIDTH(COEF_WIDTH)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_a),
    .divisor_i   (div_b),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_LOAD: begin
        if (q_valid_i && q_ctrl_i.close) state_d = B_GCD_NEXT;
      end
      B_GCD_NEXT: state_d = (idx_q == n_q) ? B_EMIT_SEL : B_GCD_EUC;
      B_GCD_EUC:  state_d = (b_q == '0) ? B_GCD_NEXT : B_GCD_WAIT;
      B_GCD_WAIT: begin
        if (div_done) state_d = B_GCD_EUC;
      end
      B_EMIT_SEL: state_d = (divide && counted) ? B_EMIT_WAIT : B_EMIT_OUT;
      B_EMIT_WAIT: begin
        if (div_done) state_d = B_EMIT_OUT;
      end
      B_EMIT_OUT: begin
        if (out_free) state_d = (idx_q + 1'b1 == n_q) ? B_LOAD : B_EMIT_SEL;
      end
      default: state_d = B_LOAD;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    n_d = n_q; idx_d = idx_q; mode_d = mode_q; g_d = g_q; a_d = a_q; b_d = b_q;
    res_d = res_q; neg_d = neg_q;
    ov_d = ov_q && !out_ready_i;
    ores_d = ores_q; ochg_d = ochg_q; odiv_d = odiv_q; olast_d = olast_q;
    q_pop_o = 1'b0; wr_en = 1'b0;
    div_start = 1'b0; div_a = a_q; div_b = b_q;
    unique case (state_q)
      B_LOAD: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          wr_en   = 1'b1;
          n_d     = q_ctrl_i.first ? CW'(1) : n_q + 1'b1;
          if (q_ctrl_i.first) mode_d = q_ctrl_i.kind;
          if (q_ctrl_i.close) begin
            idx_d = (q_ctrl_i.first ? q_ctrl_i.kind : mode_q) ? '0 : CW'(1);
            g_d   = '0;
          end
        end
      end
      B_GCD_NEXT: begin
        if (idx_q == n_q) begin
          idx_d = '0;
        end else begin
          a_d   = g_q;
          b_d   = cur_mag;
          idx_d = idx_q + 1'b1;
        end
      end
      B_GCD_EUC: begin
        if (b_q == '0) begin
          g_d = a_q;
        end else begin
          div_start = 1'b1;
        end
      end
      B_GCD_WAIT: begin
        if (div_done) begin
          a_d = b_q;
          b_d = div_rem;
        end
      end
      B_EMIT_SEL: begin
        res_d = cur;
        neg_d = cur[COEF_WIDTH-1];
        if (divide && counted) begin
          div_start = 1'b1;
          div_a     = cur_mag;
          div_b     = g_q;
        end
      end
      B_EMIT_WAIT: begin
        if (div_done) res_d = neg_q ? (~div_quo + 1'b1) : div_quo;
      end
      B_EMIT_OUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ores_d  = res_q;
          ochg_d  = divide;
          odiv_d  = g_q;
          olast_d = (idx_q + 1'b1 == n_q);
          idx_d   = idx_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_LOAD;
      n_q     <= '0;
      idx_q   <= '0;
      mode_q  <= 1'b0;
      g_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      idx_q   <= idx_d;
      mode_q  <= mode_d;
      g_q     <= g_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    res_q   <= res_d;
    neg_q   <= neg_d;
    ores_q  <= ores_d;
    ochg_q  <= ochg_d;
    odiv_q  <= odiv_d;
    olast_q <= olast_d;
    if (wr_en) store_q[wr_idx] <= q_coef_i;
  end

  assign out_valid_o   = ov_q;
  assign out_coef_o    = ores_q;
  assign out_changed_o = ochg_q;
  assign out_divisor_o = odiv_q;
  assign out_last_o    = olast_q;

  `VGN_ASSERT_IMP(a_wait_has_div, (state_q == B_GCD_WAIT || state_q == B_EMIT_WAIT), (div_busy || div_done), "waiting with no division running")
  `VGN_ASSERT_IMP(a_count_range, 1'b1, (n_q <= CW'(MAX_COLS)), "element count beyond capacity")
  `VGN_ASSERT_IMP(a_changed_gcd, (ov_q && ochg_q), (odiv_q > COEF_WIDTH'(1)), "changed flag without divisor above one")
  `VGN_ASSERT_NXT(a_start_busy, div_start, div_busy, "divider did not start")

endmodule

FILE: src/vector_gcd_normalizer_top.sv
// Top level of the vector GCD normalizer: front queue plus GCD and division engine.
// Coefficients stream in one per transfer (tuser carries the mode on the first one,
// tlast closes the vector, as does the MAX_COLS-th element). Loading accepts one
// transfer per cycle into a four-entry queue while it has room; the engine then
// computes the GCD of the counted magnitudes by Euclid's algorithm on a shared
// bit-serial divider and, if the GCD exceeds one, divides each counted
// coefficient exactly on the same divider; other elements leave without a
// division. The divider is what sets the throughput. Results leave through an
// output register, so the engine can prepare the next result while one waits
// for the downstream side, but it stalls until the register is free to emit it.
module vector_gcd_normalizer_top import vgn_pkg::*; #(
  parameter int unsigned MAX_COLS   = 16,
  parameter int unsigned COEF_WIDTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // [COEF_WIDTH-1:0] coefficient, zero padding above.
  input  logic [((COEF_WIDTH+7)/8)*8-1:0]           s_axis_tdata_i,
  // [0] kind.
  input  logic                                      s_axis_tuser_i,
  input  logic                                      s_axis_tlast_i,
  output logic                                      m_axis_tvalid_o,
  input  logic                                      m_axis_tready_i,
  // [COEF_WIDTH-1:0] result_coefficient, [2*COEF_WIDTH-1:COEF_WIDTH] divisor, padding.
  output logic [((2*COEF_WIDTH+7)/8)*8-1:0]         m_axis_tdata_o,
  // [0] changed.
  output logic                                      m_axis_tuser_o,
  output logic                                      m_axis_tlast_o
);

  localparam int unsigned OutW = ((2 * COEF_WIDTH + 7) / 8) * 8;

  logic                  q_valid, q_pop;
  vgn_ctrl_t             q_ctrl;
  logic [COEF_WIDTH-1:0] q_coef, res_coef, res_div;

  vgn_front #(.MAX_COLS(MAX_COLS), .COEF_WIDTH(COEF_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .kind_i     (s_axis_tuser_i),
    .last_i     (s_axis_tlast_i),
    .coef_i     (s_axis_tdata_i[COEF_WIDTH-1:0]),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_ctrl_o   (q_ctrl),
    .q_coef_o   (q_coef)
  );

  vgn_back #(.MAX_COLS(MAX_COLS), .COEF_WIDTH(COEF_WIDTH)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_pop_o       (q_pop),
    .q_ctrl_i      (q_ctrl),
    .q_coef_i      (q_coef),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_coef_o    (res_coef),
    .out_changed_o (m_axis_tuser_o),
    .out_divisor_o (res_div),
    .out_last_o    (m_axis_tlast_o)
  );

  // Divisor above the result coefficient; any padding bits read as zero.
  assign m_axis_tdata_o = OutW'({res_div, res_coef});

endmodule
